>>> design/tj_pkg.sv
// ----------------------------------------------------------------------------
// TinyJAMBU-128 AEAD package
// Shared constants, operation codes and control types for the AEAD core.
// ----------------------------------------------------------------------------
`default_nettype none

package tj_pkg;

	localparam int P1024 = 1024;
	localparam int P640 = 640;
	localparam int STEPS_PER_ROUND = 32;
	localparam int ROUNDS_LONG = P1024 / STEPS_PER_ROUND;
	localparam int ROUNDS_SHORT = P640 / STEPS_PER_ROUND;
	localparam int RND_W = $clog2(ROUNDS_LONG);
	localparam int WORD_W = 32;
	localparam int KEY_W = 128;

	typedef enum logic [2:0] {
		OP_START = 3'd0,
		OP_NONCE = 3'd1,
		OP_AD    = 3'd2,
		OP_TEXT  = 3'd3,
		OP_FINAL = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		CFG_KEY_LOW   = 2'd0,
		CFG_KEY_HIGH  = 2'd1,
		CFG_DIRECTION = 2'd2
	} cfg_idx_t;

	localparam logic [2:0] FRAME_NONCE = 3'd1;
	localparam logic [2:0] FRAME_AD    = 3'd3;
	localparam logic [2:0] FRAME_TEXT  = 3'd5;
	localparam logic [2:0] FRAME_FINAL = 3'd7;

	typedef enum logic [2:0] {
		CMD_HOLD,
		CMD_CLEAR,
		CMD_FRAME,
		CMD_ROUND,
		CMD_ABSORB
	} nlfsr_cmd_t;

	typedef struct packed {
		nlfsr_cmd_t cmd;
		logic [2:0] frame;
		logic [1:0] key_sel;
	} nlfsr_ctl_t;

	typedef enum logic [1:0] {
		RES_NONE,
		RES_TEXT,
		RES_TAG0,
		RES_TAG1
	} res_sel_t;

	typedef struct packed {
		logic     busy;
		res_sel_t res_sel;
		logic     save_tag0;
	} ctrl_stat_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RUN,
		S_POST,
		S_TAG1
	} state_t;

endpackage

`default_nettype wire

>>> design/tj_nlfsr.sv
// ----------------------------------------------------------------------------
// TinyJAMBU NLFSR state
// 128-bit state held as four 32-bit words; one 32-step round per cycle when commanded.
// ----------------------------------------------------------------------------
`default_nettype none

module tj_nlfsr import tj_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire nlfsr_ctl_t        ctl,
	input  wire logic [KEY_W-1:0]  key,
	input  wire logic [WORD_W-1:0] abs_w3,
	input  wire logic [1:0]        abs_w1,
	output logic      [WORD_W-1:0] w2
);

	logic [WORD_W-1:0] w_q [4];
	logic [WORD_W-1:0] key_word;
	logic [WORD_W-1:0] t1;
	logic [WORD_W-1:0] t2;
	logic [WORD_W-1:0] t3;
	logic [WORD_W-1:0] t4;
	logic [WORD_W-1:0] fb;

	always_comb begin
		key_word = key[{ctl.key_sel, 5'd0} +: WORD_W];
		t1 = {w_q[2][14:0], w_q[1][31:15]};
		t2 = {w_q[3][5:0], w_q[2][31:6]};
		t3 = {w_q[3][20:0], w_q[2][31:21]};
		t4 = {w_q[3][26:0], w_q[2][31:27]};
		fb = w_q[0] ^ t1 ^ ~(t2 & t3) ^ t4 ^ key_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				w_q[i] <= '0;
			end
		end else begin
			case (ctl.cmd)
				CMD_CLEAR: begin
					for (int i = 0; i < 4; i++) begin
						w_q[i] <= '0;
					end
				end
				CMD_FRAME: begin
					w_q[1][6:4] <= w_q[1][6:4] ^ ctl.frame;
				end
				CMD_ROUND: begin
					w_q[0] <= w_q[1];
					w_q[1] <= w_q[2];
					w_q[2] <= w_q[3];
					w_q[3] <= fb;
				end
				CMD_ABSORB: begin
					w_q[3] <= w_q[3] ^ abs_w3;
					w_q[1][1:0] <= w_q[1][1:0] ^ abs_w1;
				end
				default: begin
				end
			endcase
		end
	end

	assign w2 = w_q[2];

endmodule

`default_nettype wire

>>> design/tj_ctrl.sv
// ----------------------------------------------------------------------------
// TinyJAMBU sequencer
// Per item: clear or frame, permutation rounds, then absorb and/or result load.
// ----------------------------------------------------------------------------
`default_nettype none

module tj_ctrl import tj_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       item_valid,
	input  wire logic [2:0] op,
	input  wire logic       out_free,
	output nlfsr_ctl_t      ctl,
	output ctrl_stat_t      stat
);

	state_t           state_q;
	state_t           state_d;
	logic [RND_W-1:0] rnd_q;
	logic [RND_W-1:0] rnd_d;
	logic             long_q;
	logic             long_d;
	logic             fin2_q;
	logic             fin2_d;
	op_t              op_q;
	op_t              op_d;
	logic             rnd_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rnd_q <= '0;
			long_q <= 1'b0;
			fin2_q <= 1'b0;
			op_q <= OP_START;
		end else begin
			state_q <= state_d;
			rnd_q <= rnd_d;
			long_q <= long_d;
			fin2_q <= fin2_d;
			op_q <= op_d;
		end
	end

	always_comb begin
		rnd_last = long_q ? (rnd_q == RND_W'(ROUNDS_LONG - 1))
			: (rnd_q == RND_W'(ROUNDS_SHORT - 1));
		state_d = state_q;
		rnd_d = rnd_q;
		long_d = long_q;
		fin2_d = fin2_q;
		op_d = op_q;
		ctl.cmd = CMD_HOLD;
		ctl.frame = '0;
		ctl.key_sel = rnd_q[1:0];
		stat.busy = (state_q != S_IDLE);
		stat.res_sel = RES_NONE;
		stat.save_tag0 = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					rnd_d = '0;
					fin2_d = 1'b0;
					case (op)
						OP_START: begin
							ctl.cmd = CMD_CLEAR;
							long_d = 1'b1;
							op_d = OP_START;
							state_d = S_RUN;
						end
						OP_NONCE: begin
							ctl.cmd = CMD_FRAME;
							ctl.frame = FRAME_NONCE;
							long_d = 1'b0;
							op_d = OP_NONCE;
							state_d = S_RUN;
						end
						OP_AD: begin
							ctl.cmd = CMD_FRAME;
							ctl.frame = FRAME_AD;
							long_d = 1'b0;
							op_d = OP_AD;
							state_d = S_RUN;
						end
						OP_TEXT: begin
							ctl.cmd = CMD_FRAME;
							ctl.frame = FRAME_TEXT;
							long_d = 1'b1;
							op_d = OP_TEXT;
							state_d = S_RUN;
						end
						OP_FINAL: begin
							ctl.cmd = CMD_FRAME;
							ctl.frame = FRAME_FINAL;
							long_d = 1'b1;
							op_d = OP_FINAL;
							state_d = S_RUN;
						end
						default: begin
						end
					endcase
				end
			end
			S_RUN: begin
				ctl.cmd = CMD_ROUND;
				rnd_d = rnd_q + 1'b1;
				if (rnd_last) begin
					state_d = S_POST;
				end
			end
			S_POST: begin
				case (op_q)
					OP_NONCE, OP_AD: begin
						ctl.cmd = CMD_ABSORB;
						state_d = S_IDLE;
					end
					OP_TEXT: begin
						if (out_free) begin
							ctl.cmd = CMD_ABSORB;
							stat.res_sel = RES_TEXT;
							state_d = S_IDLE;
						end
					end
					OP_FINAL: begin
						if (!fin2_q) begin
							stat.save_tag0 = 1'b1;
							ctl.cmd = CMD_FRAME;
							ctl.frame = FRAME_FINAL;
							long_d = 1'b0;
							rnd_d = '0;
							fin2_d = 1'b1;
							state_d = S_RUN;
						end else if (out_free) begin
							stat.res_sel = RES_TAG0;
							state_d = S_TAG1;
						end
					end
					default: begin
						state_d = S_IDLE;
					end
				endcase
			end
			S_TAG1: begin
				if (out_free) begin
					stat.res_sel = RES_TAG1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> design/tinyjambu_aead_core.sv
// Start and text items run 32 rounds, nonce and AD items 20, finalize 32
// and then 20. A text result is loaded when its rounds end and the output is
// free; the two tag halves follow the second run of rounds. No new item is
// taken before the last is done. The round unit does 32 NLFSR steps per cycle
// while rounds run. Reset clears the state, key and direction.
// ----------------------------------------------------------------------------
// TinyJAMBU-128 AEAD core
// Keyed NLFSR with item sequencing, text and tag results and tag compare.
// ----------------------------------------------------------------------------
`default_nettype none

module tinyjambu_aead_core import tj_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [63:0] cfg_data,
	input  wire logic        item_valid,
	output logic             item_stall,
	input  wire logic [2:0]  op,
	input  wire logic [31:0] data_word,
	input  wire logic [2:0]  byte_count,
	input  wire logic [63:0] expected_tag,
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic [31:0]      data_out,
	output logic [2:0]       out_bytes,
	output logic             tag_ok,
	output logic             last
);

	logic [63:0]       key_low_q;
	logic [63:0]       key_high_q;
	logic              dir_q;
	logic [2:0]        op_q;
	logic [31:0]       data_q;
	logic [1:0]        n_q;
	logic [63:0]       exp_q;
	logic [31:0]       tag0_q;
	logic              res_valid_q;
	logic [31:0]       data_out_q;
	logic [2:0]        out_bytes_q;
	logic              tag_ok_q;
	logic              last_q;
	logic              accept;
	logic              out_free;
	logic [31:0]       mask;
	logic [2:0]        cnt;
	logic [31:0]       text_res;
	logic [31:0]       plain;
	logic [31:0]       abs_w3;
	logic [1:0]        abs_w1;
	logic              tag_match;
	logic [WORD_W-1:0] w2;
	nlfsr_ctl_t        ctl;
	ctrl_stat_t        stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q <= '0;
			key_high_q <= '0;
			dir_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_KEY_LOW: key_low_q <= cfg_data;
				CFG_KEY_HIGH: key_high_q <= cfg_data;
				CFG_DIRECTION: dir_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	assign item_stall = stat.busy;
	assign accept = item_valid && !item_stall;
	assign out_free = !res_valid_q || !result_stall;

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= op;
			data_q <= data_word;
			n_q <= byte_count[1:0];
			exp_q <= expected_tag;
		end
		if (stat.save_tag0) begin
			tag0_q <= w2;
		end
	end

	always_comb begin
		case (n_q)
			2'd1: mask = 32'h0000_00ff;
			2'd2: mask = 32'h0000_ffff;
			2'd3: mask = 32'h00ff_ffff;
			default: mask = 32'hffff_ffff;
		endcase
		cnt = (n_q == 2'd0) ? 3'd4 : {1'b0, n_q};
		text_res = (w2 ^ data_q) & mask;
		plain = dir_q ? text_res : (data_q & mask);
		case (op_q)
			OP_NONCE: abs_w3 = data_q;
			OP_AD: abs_w3 = data_q & mask;
			OP_TEXT: abs_w3 = plain;
			default: abs_w3 = '0;
		endcase
		abs_w1 = (op_q == OP_AD || op_q == OP_TEXT) ? n_q : 2'd0;
		tag_match = ({w2, tag0_q} == exp_q);
	end

	tj_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.op         (op),
		.out_free   (out_free),
		.ctl        (ctl),
		.stat       (stat)
	);

	tj_nlfsr u_nlfsr (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.key    ({key_high_q, key_low_q}),
		.abs_w3 (abs_w3),
		.abs_w1 (abs_w1),
		.w2     (w2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (stat.res_sel != RES_NONE) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (stat.res_sel)
			RES_TEXT: begin
				data_out_q <= text_res;
				out_bytes_q <= cnt;
				tag_ok_q <= 1'b0;
				last_q <= 1'b1;
			end
			RES_TAG0: begin
				data_out_q <= tag0_q;
				out_bytes_q <= 3'd4;
				tag_ok_q <= tag_match;
				last_q <= 1'b0;
			end
			RES_TAG1: begin
				data_out_q <= w2;
				out_bytes_q <= 3'd4;
				tag_ok_q <= tag_match;
				last_q <= 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign result_valid = res_valid_q;
	assign data_out = data_out_q;
	assign out_bytes = out_bytes_q;
	assign tag_ok = tag_ok_q;
	assign last = last_q;

endmodule

`default_nettype wire

>>> design/tj_checker.sv
// ----------------------------------------------------------------------------
// TinyJAMBU core checker
// Port-level properties of the AEAD core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tj_checker import tj_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        item_valid,
	input wire logic        item_stall,
	input wire logic [2:0]  op,
	input wire logic        result_valid,
	input wire logic        result_stall,
	input wire logic [31:0] data_out,
	input wire logic [2:0]  out_bytes,
	input wire logic        tag_ok,
	input wire logic        last
);

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(data_out))
		else $error("result item dropped or changed while stalled");

	a_busy_after_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && op <= OP_FINAL |=> item_stall)
		else $error("core not busy after accepting an item");

	a_tag_first_half: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last |-> out_bytes == 3'd4)
		else $error("first tag half without a full word");

	a_tag_ok_full: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && tag_ok |-> out_bytes == 3'd4)
		else $error("tag match flag on a text result");

endmodule

bind tinyjambu_aead_core tj_checker u_tj_checker (.*);

`default_nettype wire

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// TinyJAMBU-128 AEAD core testbench
// Drives start, nonce, associated-data, text and finalize items through the
// core under several keys and both directions. Each accepted item is run
// through a bit-exact model of the keyed NLFSR, and every text word and tag
// half is compared in order with what the model expects. Items go in bursts
// with random gaps, and the result side stalls with changing intensity.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tj_pkg::*;

	localparam logic [1:0] CFG_SPARE = 2'd3;
	localparam logic [2:0] OP_RSVD0 = 3'd5;
	localparam logic [2:0] OP_RSVD1 = 3'd6;
	localparam logic [2:0] OP_RSVD2 = 3'd7;
	localparam int SETTLE_CYCLES = 64;
	localparam int PHASE_ITEMS = 200;
	localparam int N_DIRECTED = 24;

	typedef struct packed {
		logic [31:0] data_out;
		logic [2:0]  out_bytes;
		logic        tag_ok;
		logic        last;
	} result_word_t;

	typedef struct {
		logic [2:0]  code;
		logic [31:0] data;
		logic [2:0]  count;
		logic [63:0] tag;
		bit          tag_rel;
		int          typed_bytes;
	} stim_row_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [63:0] cfg_data = '0;
	logic        item_valid = 1'b0;
	logic        item_stall;
	logic [2:0]  op = OP_START;
	logic [31:0] data_word = '0;
	logic [2:0]  byte_count = 3'd4;
	logic [63:0] expected_tag = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [31:0] data_out;
	logic [2:0]  out_bytes;
	logic        tag_ok;
	logic        last;

	logic [127:0] cipher_st = '0;
	logic [127:0] cipher_key = '0;
	logic         decrypt = 1'b0;
	result_word_t expected_words[$];
	int           fault_count = 0;
	int           items_sent = 0;
	int           burst_left = 0;
	int           stall_left = 0;
	int           stall_pct = 0;
	int           stall_pcts[4] = '{0, 25, 60, 90};
	result_word_t seen;
	result_word_t want;

	stim_row_t directed_rows[N_DIRECTED] = '{
		'{OP_TEXT,  32'hFFFF_FFFF, 3'd4, 64'd0, 1'b0, 4},
		'{OP_FINAL, 32'h0000_0000, 3'd4, 64'd0, 1'b0, -1},
		'{OP_START, 32'h0000_0000, 3'd4, 64'd0, 1'b0, -1},
		'{OP_NONCE, 32'h0000_0000, 3'd4, 64'd0, 1'b0, -1},
		'{OP_NONCE, 32'hFFFF_FFFF, 3'd4, 64'd0, 1'b0, -1},
		'{OP_NONCE, 32'h0123_4567, 3'd4, 64'd0, 1'b0, -1},
		'{OP_AD,    32'hFFFF_FFFF, 3'd4, 64'd0, 1'b0, -1},
		'{OP_AD,    32'h8BAD_F00D, 3'd0, 64'd0, 1'b0, -1},
		'{OP_AD,    32'hFFFF_FFFF, 3'd1, 64'd0, 1'b0, -1},
		'{OP_AD,    32'hFFFF_FFFF, 3'd2, 64'd0, 1'b0, -1},
		'{OP_AD,    32'hFFFF_FFFF, 3'd3, 64'd0, 1'b0, -1},
		'{OP_AD,    32'h5A5A_5A5A, 3'd7, 64'd0, 1'b0, -1},
		'{OP_TEXT,  32'h0000_0000, 3'd4, 64'd0, 1'b0, 4},
		'{OP_TEXT,  32'hFFFF_FFFF, 3'd0, 64'd0, 1'b0, 4},
		'{OP_TEXT,  32'hFFFF_FFFF, 3'd1, 64'd0, 1'b0, 1},
		'{OP_TEXT,  32'hFFFF_FFFF, 3'd2, 64'd0, 1'b0, 2},
		'{OP_TEXT,  32'hFFFF_FFFF, 3'd3, 64'd0, 1'b0, 3},
		'{OP_TEXT,  32'hFFFF_FFFF, 3'd5, 64'd0, 1'b0, 1},
		'{OP_TEXT,  32'h1357_9BDF, 3'd6, 64'd0, 1'b0, 2},
		'{OP_RSVD0, 32'h0000_0000, 3'd4, 64'd0, 1'b0, -1},
		'{OP_RSVD1, 32'hFFFF_FFFF, 3'd0, 64'd0, 1'b0, -1},
		'{OP_RSVD2, 32'hFFFF_FFFF, 3'd7, '1,    1'b0, -1},
		'{OP_FINAL, 32'h0000_0000, 3'd4, 64'd0, 1'b1, -1},
		'{OP_FINAL, 32'hFFFF_FFFF, 3'd4, '1,    1'b0, -1}
	};

	tinyjambu_aead_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.op(op),
		.data_word(data_word),
		.byte_count(byte_count),
		.expected_tag(expected_tag),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.data_out(data_out),
		.out_bytes(out_bytes),
		.tag_ok(tag_ok),
		.last(last)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("status: fail");
		$finish;
	end

	function automatic logic [127:0] jambu_rounds(input logic [127:0] s, input int rounds);
		logic [127:0] t;
		logic [31:0] fb;
		int r;
		t = s;
		for (r = 0; r < rounds; r++) begin
			fb = t[31:0] ^ t[47 +: 32] ^ ~(t[70 +: 32] & t[85 +: 32]) ^ t[91 +: 32]
				^ cipher_key[32 * (r % 4) +: 32];
			t = {fb, t[127:32]};
		end
		return t;
	endfunction

	function automatic logic [127:0] seal_state(input logic [127:0] s, output logic [63:0] tag);
		logic [127:0] t;
		t = s;
		t[36 +: 3] ^= FRAME_FINAL;
		t = jambu_rounds(t, ROUNDS_LONG);
		tag[31:0] = t[64 +: 32];
		t[36 +: 3] ^= FRAME_FINAL;
		t = jambu_rounds(t, ROUNDS_SHORT);
		tag[63:32] = t[64 +: 32];
		return t;
	endfunction

	task automatic predict_item(input logic [2:0] code, input logic [31:0] d,
			input logic [2:0] bc, input logic [63:0] tg, input int typed_bytes);
		logic [1:0] n;
		logic [2:0] cnt;
		logic [31:0] mask;
		logic [31:0] res;
		logic [63:0] tag;
		n = bc[1:0];
		cnt = (n == 2'd0) ? 3'd4 : {1'b0, n};
		mask = (n == 2'd0) ? '1 : (32'hFFFF_FFFF >> (8 * (4 - int'(n))));
		case (code)
			OP_START: begin
				cipher_st = jambu_rounds('0, ROUNDS_LONG);
			end
			OP_NONCE: begin
				cipher_st[36 +: 3] ^= FRAME_NONCE;
				cipher_st = jambu_rounds(cipher_st, ROUNDS_SHORT);
				cipher_st[96 +: 32] ^= d;
			end
			OP_AD: begin
				cipher_st[36 +: 3] ^= FRAME_AD;
				cipher_st = jambu_rounds(cipher_st, ROUNDS_SHORT);
				cipher_st[96 +: 32] ^= d & mask;
				cipher_st[32 +: 32] ^= {30'd0, n};
			end
			OP_TEXT: begin
				cipher_st[36 +: 3] ^= FRAME_TEXT;
				cipher_st = jambu_rounds(cipher_st, ROUNDS_LONG);
				res = (cipher_st[64 +: 32] ^ d) & mask;
				cipher_st[96 +: 32] ^= decrypt ? res : (d & mask);
				cipher_st[32 +: 32] ^= {30'd0, n};
				expected_words.push_back('{res, (typed_bytes >= 0) ? typed_bytes[2:0] : cnt,
					1'b0, 1'b1});
			end
			OP_FINAL: begin
				cipher_st = seal_state(cipher_st, tag);
				expected_words.push_back('{tag[31:0], 3'd4, tag == tg, 1'b0});
				expected_words.push_back('{tag[63:32], 3'd4, tag == tg, 1'b1});
			end
			default: begin
			end
		endcase
	endtask

	// With tag_rel set, tg is a bit mask applied to the tag the core should compute.
	task automatic send_item(input logic [2:0] code, input logic [31:0] d, input logic [2:0] bc,
			input logic [63:0] tg, input bit tag_rel, input int typed_bytes);
		logic [63:0] true_tag;
		logic [63:0] sent_tag;
		void'(seal_state(cipher_st, true_tag));
		sent_tag = tag_rel ? (true_tag ^ tg) : tg;
		op <= code;
		data_word <= d;
		byte_count <= bc;
		expected_tag <= sent_tag;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		predict_item(code, d, bc, sent_tag, typed_bytes);
		if (code <= OP_FINAL)
			items_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			if ($urandom_range(0, 3) != 0) begin
				item_valid <= 1'b0;
				repeat ($urandom_range(1, 60))
					@(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
	endtask

	task automatic send_word(input logic [2:0] code, input bit final_word);
		logic [2:0] bc;
		if ($urandom_range(0, 11) == 0)
			send_item($urandom_range(0, 7), $urandom, $urandom_range(0, 7),
				{$urandom, $urandom}, 1'b0, -1);
		if (final_word && $urandom_range(0, 1) == 1)
			bc = $urandom_range(1, 3) + ($urandom_range(0, 3) == 0 ? 4 : 0);
		else
			bc = ($urandom_range(0, 3) == 0) ? 3'd0 : 3'd4;
		send_item(code, $urandom, bc, {$urandom, $urandom}, 1'b0, -1);
	endtask

	task automatic run_message();
		int n_ad;
		int n_text;
		int i;
		int pick;
		n_ad = $urandom_range(0, 4);
		n_text = $urandom_range(0, 6);
		if ($urandom_range(0, 7) != 0)
			send_word(OP_START, 1'b0);
		repeat (3)
			send_word(OP_NONCE, 1'b0);
		for (i = 0; i < n_ad; i++)
			send_word(OP_AD, i == n_ad - 1);
		for (i = 0; i < n_text; i++)
			send_word(OP_TEXT, i == n_text - 1);
		pick = $urandom_range(0, 9);
		if (pick < 6)
			send_item(OP_FINAL, $urandom, 3'd4, 64'd0, 1'b1, -1);
		else if (pick < 9)
			send_item(OP_FINAL, $urandom, 3'd4, 64'd1 << $urandom_range(0, 63), 1'b1, -1);
		else
			send_item(OP_FINAL, $urandom, 3'd4, {$urandom, $urandom}, 1'b0, -1);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [63:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_KEY_LOW: cipher_key[63:0] = v;
			CFG_KEY_HIGH: cipher_key[127:64] = v;
			CFG_DIRECTION: decrypt = v[0];
			default: begin
			end
		endcase
		@(posedge clk);
	endtask

	// Items that give no result may still be in flight when the queue empties.
	task automatic settle();
		item_valid <= 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_pct <= stall_pcts[$urandom_range(0, 3)];
			stall_left <= $urandom_range(40, 400);
		end else begin
			stall_left <= stall_left - 1;
		end
		result_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			seen = '{data_out, out_bytes, tag_ok, last};
			if (expected_words.size() == 0) begin
				fault_count++;
				if (fault_count <= 10)
					$display("unexpected result: data_out=%h out_bytes=%0d tag_ok=%b last=%b",
						seen.data_out, seen.out_bytes, seen.tag_ok, seen.last);
			end else begin
				want = expected_words.pop_front();
				if (seen !== want) begin
					fault_count++;
					if (fault_count <= 10)
						$display("mismatch: expected %h/%0d/%b/%b, got %h/%0d/%b/%b",
							want.data_out, want.out_bytes, want.tag_ok, want.last,
							seen.data_out, seen.out_bytes, seen.tag_ok, seen.last);
				end
			end
		end
	end

	initial begin : stimulus
		int i;
		int p;
		int phase_goal;
		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < N_DIRECTED; i++)
			send_item(directed_rows[i].code, directed_rows[i].data, directed_rows[i].count,
				directed_rows[i].tag, directed_rows[i].tag_rel, directed_rows[i].typed_bytes);
		settle();

		for (p = 0; p < 6; p++) begin
			case (p)
				0: begin
					write_reg(CFG_KEY_LOW, '0);
					write_reg(CFG_KEY_HIGH, '1);
					write_reg(CFG_DIRECTION, '1);
				end
				1: begin
					write_reg(CFG_KEY_LOW, '1);
					write_reg(CFG_KEY_HIGH, '1);
					write_reg(CFG_DIRECTION, {$urandom, $urandom} & ~64'd1);
				end
				default: begin
					write_reg(CFG_KEY_LOW, {$urandom, $urandom});
					write_reg(CFG_KEY_HIGH, {$urandom, $urandom});
					write_reg(CFG_DIRECTION, {$urandom, $urandom});
					if (p == 3)
						write_reg(CFG_SPARE, {$urandom, $urandom});
				end
			endcase
			phase_goal = items_sent + PHASE_ITEMS;
			while (items_sent < phase_goal)
				run_message();
			settle();
		end

		fault_count += expected_words.size();
		if (fault_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

>>> sim.f
design/tj_pkg.sv
design/tj_nlfsr.sv
design/tj_ctrl.sv
design/tinyjambu_aead_core.sv
design/tj_checker.sv
tb/tb.sv
